// ----- sv/ppe_pkg.sv -----
// Shared constants and controller/datapath interface types for the plane equation unit.
`default_nettype none
package ppe_pkg;

  localparam int MAX_VERTS = 32;
  localparam int ADDR_W    = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);

  localparam int FACE_W  = 16;
  localparam int COORD_W = 24;
  localparam int VERT_W  = 3 * COORD_W;
  localparam int NORM_W  = 16;
  localparam int DIST_W  = 25;

  localparam logic [NORM_W-1:0] Q_ONE    = 16'd16384;
  localparam logic [4:0]        DIV_LAST = 5'd15;

  typedef struct packed {
    logic load;
    logic rd;
    logic shift;
    logic diff;
    logic mul;
    logic xprod;
    logic test;
    logic norm;
    logic sq;
    logic sum;
    logic sqrt;
    logic dload;
    logic div;
    logic dstore;
    logic dot;
    logic acc;
    logic fin;
    logic emit;
  } ppe_cmd_t;

  typedef struct packed {
    logic last_accept;
    logic win_full;
    logic k_last;
    logic nonzero;
    logic norm_done;
    logic sqrt_done;
    logic div_done;
    logic comp_last;
    logic out_free;
  } ppe_status_t;

endpackage
`default_nettype wire

// ----- sv/ppe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppe_ctrl.sv -----
// Controller state machine sequencing load, edge search, normalization, square root, division, distance and output.
`default_nettype none
module ppe_ctrl import ppe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ppe_status_t status,
  output ppe_cmd_t         cmd
);

  typedef enum logic [17:0] {
    S_LOAD   = 18'h00001,
    S_RD     = 18'h00002,
    S_SH     = 18'h00004,
    S_DIFF   = 18'h00008,
    S_MUL    = 18'h00010,
    S_XPROD  = 18'h00020,
    S_TEST   = 18'h00040,
    S_NORM   = 18'h00080,
    S_SQ     = 18'h00100,
    S_SUM    = 18'h00200,
    S_SQRT   = 18'h00400,
    S_DLOAD  = 18'h00800,
    S_DIV    = 18'h01000,
    S_DSTORE = 18'h02000,
    S_DOT    = 18'h04000,
    S_ACC    = 18'h08000,
    S_FIN    = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.last_accept) state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SH;
      end
      S_SH: begin
        cmd.shift  = 1'b1;
        state_next = status.win_full ? S_DIFF : S_RD;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_XPROD;
      end
      S_XPROD: begin
        cmd.xprod  = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (status.nonzero) state_next = S_NORM;
        else if (status.k_last) state_next = S_EMIT;
        else state_next = S_RD;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (status.norm_done) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (status.sqrt_done) state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.dload  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (status.div_done) state_next = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.dstore = 1'b1;
        state_next = status.comp_last ? S_DOT : S_DLOAD;
      end
      S_DOT: begin
        cmd.dot    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/ppe_datapath.sv -----
// Datapath: vertex store, edge window, cross product, square root, divider and output register.
`default_nettype none
module ppe_datapath import ppe_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ppe_cmd_t                  cmd,
  output ppe_status_t                    status,
  input  wire logic                      vertex_valid,
  input  wire logic [FACE_W-1:0]         face_id,
  input  wire logic signed [COORD_W-1:0] vertex_x,
  input  wire logic signed [COORD_W-1:0] vertex_y,
  input  wire logic signed [COORD_W-1:0] vertex_z,
  input  wire logic                      last_vertex,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [FACE_W-1:0]              result_face,
  output logic signed [NORM_W-1:0]       normal_x,
  output logic signed [NORM_W-1:0]       normal_y,
  output logic signed [NORM_W-1:0]       normal_z,
  output logic signed [DIST_W-1:0]       plane_dist,
  output logic                           degenerate
);

  logic                      accept;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          last_idx;
  logic [FACE_W-1:0]         held_face;
  logic signed [COORD_W-1:0] v0 [3];
  logic                      we;
  logic [VERT_W-1:0]         rdata;
  logic [ADDR_W-1:0]         rd_addr;
  logic [1:0]                fill;
  logic [CNT_W-1:0]          kcnt;

  logic signed [COORD_W-1:0] wx [3];
  logic signed [COORD_W-1:0] wy [3];
  logic signed [COORD_W-1:0] wz [3];
  logic signed [24:0]        ax, ay, az, bx, by, bz;
  logic signed [49:0]        p [6];
  logic signed [50:0]        c [3];
  logic [50:0]               m [3];
  logic                      ng [3];
  logic                      degen;
  logic                      big, tiny;

  logic [59:0]               s [3];
  logic [61:0]               sv;
  logic [62:0]               root;
  logic [62:0]               bitv;
  logic [63:0]               trial;
  logic [30:0]               mag;

  logic [1:0]                comp;
  logic [44:0]               num;
  logic [31:0]               rem;
  logic [31:0]               rem_try;
  logic [15:0]               nlow;
  logic [15:0]               q;
  logic [15:0]               qc;
  logic [4:0]                dcnt;
  logic signed [NORM_W-1:0]  nv [3];
  logic signed [39:0]        d [3];
  logic signed [41:0]        acc;
  logic [41:0]               acc_mag;
  logic [27:0]               rnd;
  logic [DIST_W-1:0]         pdist;
  logic [DIST_W-1:0]         pdist_next;

  assign accept   = cmd.load & vertex_valid;
  assign we       = accept & (count < CNT_W'(MAX_VERTS));
  assign last_idx = count - 1'b1;

  ppe_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({vertex_x, vertex_y, vertex_z}),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign big   = (m[0][50:30] != '0) | (m[1][50:30] != '0) | (m[2][50:30] != '0);
  assign tiny  = (m[0][50:29] == '0) & (m[1][50:29] == '0) & (m[2][50:29] == '0);
  assign trial = {1'b0, root} + {1'b0, bitv};
  assign mag   = root[30:0];
  assign rem_try = {rem[30:0], nlow[15]};
  assign qc    = (q > Q_ONE) ? Q_ONE : q;
  assign acc_mag = acc[41] ? 42'(-acc) : 42'(acc);
  assign rnd   = 28'((acc_mag + 42'd8192) >> 14);
  assign num   = {1'b0, m[comp][29:0], 14'd0} + 45'(mag[30:1]);

  always_comb begin
    if (acc[41]) begin
      pdist_next = (rnd > 28'd16777216) ? 25'h1000000 : 25'(25'd0 - 25'(rnd));
    end else begin
      pdist_next = (rnd > 28'd16777215) ? 25'h0FFFFFF : 25'(rnd);
    end
  end

  always_comb begin
    status.last_accept = accept & last_vertex;
    status.win_full    = (fill == 2'd2);
    status.k_last      = (kcnt == last_idx);
    status.nonzero     = (c[0] != '0) | (c[1] != '0) | (c[2] != '0);
    status.norm_done   = ~big & ~tiny;
    status.sqrt_done   = bitv[0];
    status.div_done    = (dcnt == DIV_LAST);
    status.comp_last   = (comp == 2'd2);
    status.out_free    = ~result_valid | ~result_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      held_face    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (count == '0) held_face <= face_id;
        if (count < CNT_W'(MAX_VERTS)) count <= count + 1'b1;
      end
      if (cmd.emit) begin
        count        <= '0;
        result_valid <= 1'b1;
      end else if (result_valid & ~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // search sequencing
  always_ff @(posedge clk) begin
    if (accept & last_vertex) begin
      rd_addr <= '0;
      fill    <= '0;
      kcnt    <= '0;
    end
    if (accept & (count == '0)) begin
      v0[0] <= vertex_x;
      v0[1] <= vertex_y;
      v0[2] <= vertex_z;
    end
    if (cmd.shift) begin
      wx[0] <= wx[1]; wx[1] <= wx[2]; wx[2] <= rdata[71:48];
      wy[0] <= wy[1]; wy[1] <= wy[2]; wy[2] <= rdata[47:24];
      wz[0] <= wz[1]; wz[1] <= wz[2]; wz[2] <= rdata[23:0];
      if (fill != 2'd2) fill <= fill + 2'd1;
      rd_addr <= (rd_addr == last_idx[ADDR_W-1:0]) ? '0 : rd_addr + 1'b1;
    end
    if (cmd.diff) begin
      ax <= $signed({wx[1][23], wx[1]}) - $signed({wx[0][23], wx[0]});
      ay <= $signed({wy[1][23], wy[1]}) - $signed({wy[0][23], wy[0]});
      az <= $signed({wz[1][23], wz[1]}) - $signed({wz[0][23], wz[0]});
      bx <= $signed({wx[1][23], wx[1]}) - $signed({wx[2][23], wx[2]});
      by <= $signed({wy[1][23], wy[1]}) - $signed({wy[2][23], wy[2]});
      bz <= $signed({wz[1][23], wz[1]}) - $signed({wz[2][23], wz[2]});
    end
    if (cmd.mul) begin
      p[0] <= ay * bz;
      p[1] <= az * by;
      p[2] <= az * bx;
      p[3] <= ax * bz;
      p[4] <= ax * by;
      p[5] <= ay * bx;
    end
    if (cmd.xprod) begin
      c[0] <= $signed({p[0][49], p[0]}) - $signed({p[1][49], p[1]});
      c[1] <= $signed({p[2][49], p[2]}) - $signed({p[3][49], p[3]});
      c[2] <= $signed({p[4][49], p[4]}) - $signed({p[5][49], p[5]});
    end
    if (cmd.test) begin
      for (int i = 0; i < 3; i++) begin
        m[i]  <= c[i][50] ? 51'(-c[i]) : 51'(c[i]);
        ng[i] <= c[i][50];
      end
      kcnt  <= kcnt + 1'b1;
      degen <= ~status.nonzero;
    end
    if (cmd.norm) begin
      for (int i = 0; i < 3; i++) begin
        if (big) m[i] <= m[i] >> 1;
        else if (tiny) m[i] <= m[i] << 1;
      end
    end
    if (cmd.sq) begin
      for (int i = 0; i < 3; i++) begin
        s[i] <= m[i][29:0] * m[i][29:0];
      end
    end
    if (cmd.sum) begin
      sv   <= {2'b00, s[0]} + {2'b00, s[1]} + {2'b00, s[2]};
      root <= '0;
      bitv <= {1'b1, 62'd0};
      comp <= '0;
    end
    if (cmd.sqrt) begin
      if ({2'b00, sv} >= trial) begin
        sv   <= sv - trial[61:0];
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.dload) begin
      rem  <= {3'd0, num[44:16]};
      nlow <= num[15:0];
      q    <= '0;
      dcnt <= '0;
    end
    if (cmd.div) begin
      if (rem_try >= {1'b0, mag}) begin
        rem <= rem_try - {1'b0, mag};
        q   <= {q[14:0], 1'b1};
      end else begin
        rem <= rem_try;
        q   <= {q[14:0], 1'b0};
      end
      nlow <= nlow << 1;
      dcnt <= dcnt + 5'd1;
    end
    if (cmd.dstore) begin
      nv[comp] <= ng[comp] ? $signed(16'd0 - qc) : $signed(qc);
      comp     <= comp + 2'd1;
    end
    if (cmd.dot) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= nv[i] * v0[i];
      end
    end
    if (cmd.acc) begin
      acc <= 42'(d[0]) + 42'(d[1]) + 42'(d[2]);
    end
    if (cmd.fin) begin
      pdist <= pdist_next;
    end
    if (cmd.emit) begin
      result_face <= held_face;
      degenerate  <= degen;
      if (degen) begin
        normal_x   <= '0;
        normal_y   <= '0;
        normal_z   <= '0;
        plane_dist <= '0;
      end else begin
        normal_x   <= nv[0];
        normal_y   <= nv[1];
        normal_z   <= nv[2];
        plane_dist <= $signed(pdist);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/polygon_plane_equation.sv -----
// Top level of the polygon plane equation unit.
// Vertices of a face load one per cycle into a vertex RAM (up to 32 kept, further ones
// dropped); the face identifier and first vertex are taken from the face's first vertex.
// After the last vertex, vertex_stall stays high while the unit walks the corners: two
// priming RAM reads, then for each corner tested a read, window shift, edge differences,
// multiply, cross product and zero test. A degenerate face then goes straight to emit.
// Otherwise the normal is scaled one bit per cycle, then come a bit-serial square root, a
// shared restoring divider for each of the three components in turn, and the distance
// (dot, accumulate, finish). The result sits in an output register, so the next face can
// start loading while it waits to be taken. The vertex RAM needs no clearing after reset.
`default_nettype none
module polygon_plane_equation import ppe_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      vertex_valid,
  output logic                           vertex_stall,
  input  wire logic [FACE_W-1:0]         face_id,
  input  wire logic signed [COORD_W-1:0] vertex_x,
  input  wire logic signed [COORD_W-1:0] vertex_y,
  input  wire logic signed [COORD_W-1:0] vertex_z,
  input  wire logic                      last_vertex,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [FACE_W-1:0]              result_face,
  output logic signed [NORM_W-1:0]       normal_x,
  output logic signed [NORM_W-1:0]       normal_y,
  output logic signed [NORM_W-1:0]       normal_z,
  output logic signed [DIST_W-1:0]       plane_dist,
  output logic                           degenerate
);

  ppe_cmd_t    cmd;
  ppe_status_t status;

  assign vertex_stall = ~cmd.load;

  ppe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ppe_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .vertex_valid (vertex_valid),
    .face_id      (face_id),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .last_vertex  (last_vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_face  (result_face),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_dist   (plane_dist),
    .degenerate   (degenerate)
  );

endmodule
`default_nettype wire

// ----- verif/ppe_checker.sv -----
// Checker for the plane equation unit: predicts each face's plane and compares results.
`timescale 1ns / 1ps
module ppe_checker import ppe_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      vertex_valid,
  input  wire logic                      vertex_stall,
  input  wire logic [FACE_W-1:0]         face_id,
  input  wire logic signed [COORD_W-1:0] vertex_x,
  input  wire logic signed [COORD_W-1:0] vertex_y,
  input  wire logic signed [COORD_W-1:0] vertex_z,
  input  wire logic                      last_vertex,
  input  wire logic                      result_valid,
  input  wire logic                      result_stall,
  input  wire logic [FACE_W-1:0]         result_face,
  input  wire logic signed [NORM_W-1:0]  normal_x,
  input  wire logic signed [NORM_W-1:0]  normal_y,
  input  wire logic signed [NORM_W-1:0]  normal_z,
  input  wire logic signed [DIST_W-1:0]  plane_dist,
  input  wire logic                      degenerate,
  output int                             failures,
  output int                             planes_pending
);

  typedef struct packed {
    logic [FACE_W-1:0]        face;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic signed [DIST_W-1:0] pdist;
    logic                     degen;
  } plane_t;

  plane_t plane_q[$];
  logic signed [COORD_W-1:0] vx[MAX_VERTS];
  logic signed [COORD_W-1:0] vy[MAX_VERTS];
  logic signed [COORD_W-1:0] vz[MAX_VERTS];
  int unsigned vcount;
  logic [FACE_W-1:0] cur_face;

  assign planes_pending = plane_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic plane_t face_plane();
    plane_t p;
    longint c[3], ax, ay, az, bx, by, bz, nv[3], acc;
    longint unsigned m[3], mx, sq, mag, q, a;
    bit neg[3], found;
    int unsigned n, cu, nx, pv;
    n = vcount;
    found = 0;
    p = '0;
    p.face = cur_face;
    for (int unsigned k = 1; k <= n && !found; k++) begin
      cu = k % n;
      nx = (k + 1) % n;
      pv = (k + n - 1) % n;
      ax = longint'(vx[cu]) - longint'(vx[pv]);
      ay = longint'(vy[cu]) - longint'(vy[pv]);
      az = longint'(vz[cu]) - longint'(vz[pv]);
      bx = longint'(vx[cu]) - longint'(vx[nx]);
      by = longint'(vy[cu]) - longint'(vy[nx]);
      bz = longint'(vz[cu]) - longint'(vz[nx]);
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
      found = (c[0] != 0 || c[1] != 0 || c[2] != 0);
    end
    if (!found) begin
      p.degen = 1'b1;
      return p;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    mag = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + mag / 2) / mag;
      if (q > 16384) q = 16384;
      nv[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    p.nx = nv[0][NORM_W-1:0];
    p.ny = nv[1][NORM_W-1:0];
    p.nz = nv[2][NORM_W-1:0];
    acc = nv[0] * longint'(vx[0]) + nv[1] * longint'(vy[0]) + nv[2] * longint'(vz[0]);
    a = (acc < 0) ? longint'(-acc) : longint'(acc);
    a = (a + 8192) >> 14;
    if (acc < 0) begin
      if (a > (64'd1 << 24)) a = 64'd1 << 24;
      acc = -longint'(a);
    end else begin
      if (a > (64'd1 << 24) - 1) a = (64'd1 << 24) - 1;
      acc = longint'(a);
    end
    p.pdist = acc[DIST_W-1:0];
    return p;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    plane_t want;
    if (rst) begin
      vcount = 0;
      cur_face = '0;
      plane_q.delete();
      failures = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (plane_q.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = plane_q.pop_front();
          if (result_face !== want.face) report_mismatch("result_face", result_face, want.face);
          if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
          if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
          if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
          if (plane_dist !== want.pdist) report_mismatch("plane_dist", plane_dist, want.pdist);
          if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
        end
      end
      if (vertex_valid && !vertex_stall) begin
        if (vcount == 0) cur_face = face_id;
        if (vcount < MAX_VERTS) begin
          vx[vcount] = vertex_x;
          vy[vcount] = vertex_y;
          vz[vcount] = vertex_z;
          vcount++;
        end
        if (last_vertex) begin
          plane_q.push_back(face_plane());
          vcount = 0;
        end
      end
    end
  end

endmodule

// ----- verif/tb_polygon_plane_equation.sv -----
// Testbench top for the plane equation unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_polygon_plane_equation;
  import ppe_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int DRAIN_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vertex_valid = 1'b0;
  logic vertex_stall;
  logic [FACE_W-1:0] face_id = '0;
  logic signed [COORD_W-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic last_vertex = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [FACE_W-1:0] result_face;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic signed [DIST_W-1:0] plane_dist;
  logic degenerate;
  int failures, planes_pending;
  bit quiet = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int holdoff = 0;
  int vertices_sent = 0;
  logic signed [COORD_W-1:0] pool_base[3], pool_dir[3];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  polygon_plane_equation dut (.*);

  ppe_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) if (vertex_valid && !vertex_stall) vertices_sent++;

  always @(negedge clk) begin
    if (cycle_count == 3000) holdoff = HOLDOFF_CYCLES;
    if (holdoff > 0) begin
      result_stall <= 1'b1;
      holdoff--;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < 30);
    end
  end

  task automatic send_vertex(logic [FACE_W-1:0] f, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                             logic last);
    vertex_valid <= 1'b1;
    face_id <= f;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    last_vertex <= last;
    do @(posedge clk); while (vertex_stall);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 30) begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode, int axis);
    case (mode)
      0: return COORD_W'($urandom());
      1: return COORD_W'($signed($urandom_range(0, 2047)) - 1024);
      default: return COORD_W'(pool_base[axis] + pool_dir[axis] * $signed($urandom_range(0, 3)));
    endcase
  endfunction

  task automatic send_face(logic signed [COORD_W-1:0] pts[][3], logic [FACE_W-1:0] f);
    foreach (pts[i])
      send_vertex((i == 0) ? f : FACE_W'($urandom()), pts[i][0], pts[i][1], pts[i][2],
                  i == pts.size() - 1);
  endtask

  task automatic random_face();
    logic signed [COORD_W-1:0] pts[][3];
    int n, mode, pick;
    pick = $urandom_range(99);
    n = (pick < 5) ? $urandom_range(1, 2) : (pick < 92) ? $urandom_range(3, 8) :
        $urandom_range(9, 40);
    mode = $urandom_range(2);
    for (int a = 0; a < 3; a++) begin
      pool_base[a] = COORD_W'($signed($urandom_range(0, 65535)) - 32768);
      pool_dir[a] = COORD_W'($signed($urandom_range(0, 511)) - 256);
    end
    pts = new[n];
    foreach (pts[i])
      for (int a = 0; a < 3; a++)
        pts[i][a] = ($urandom_range(9) == 0) ? rand_coord($urandom_range(2), a)
                                              : rand_coord(mode, a);
    send_face(pts, FACE_W'($urandom()));
  endtask

  localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] CMIN = -24'sh800000;

  initial begin
    int sent;
    logic signed [COORD_W-1:0] pts[][3];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pts = '{'{24'sd5, 24'sd6, 24'sd7}};
    send_face(pts, 16'h0000);
    pts = '{'{24'sd0, 24'sd0, 24'sd0}, '{24'sd256, 24'sd0, 24'sd0}};
    send_face(pts, 16'hFFFF);
    pts = '{'{24'sd0, 24'sd0, 24'sd0}, '{24'sd10, 24'sd10, 24'sd10}, '{24'sd20, 24'sd20, 24'sd20}};
    send_face(pts, 16'h1234);
    pts = '{'{24'sd3, 24'sd3, 24'sd3}, '{24'sd3, 24'sd3, 24'sd3}, '{24'sd3, 24'sd3, 24'sd3}};
    send_face(pts, 16'h0001);
    pts = '{'{24'sd0, 24'sd0, 24'sd256}, '{24'sd256, 24'sd0, 24'sd256}, '{24'sd0, 24'sd256, 24'sd256}};
    send_face(pts, 16'h0002);
    pts = '{'{CMAX, CMAX, CMAX}, '{CMIN, CMAX, CMIN}, '{CMAX, CMIN, CMIN}};
    send_face(pts, 16'h8000);
    pts = '{'{CMIN, CMIN, CMIN}, '{CMAX, CMIN, CMAX}, '{CMIN, CMAX, CMAX}};
    send_face(pts, 16'h7FFF);
    pts = '{'{24'sd0, 24'sd0, 24'sd0}, '{24'sd1, 24'sd0, 24'sd0}, '{24'sd1, 24'sd0, 24'sd0},
            '{24'sd1, 24'sd0, 24'sd0}, '{24'sd0, 24'sd1, 24'sd1}};
    send_face(pts, 16'h0003);
    pts = '{'{24'sd1, 24'sd2, 24'sd3}, '{24'sd1, 24'sd2, 24'sd3}, '{24'sd4, 24'sd9, 24'sd3},
            '{24'sd4, 24'sd9, 24'sd3}};
    send_face(pts, 16'h0004);
    pts = new[34];
    foreach (pts[i]) pts[i] = '{COORD_W'(i * 100), COORD_W'((i * i) % 77), COORD_W'(-i * 3)};
    send_face(pts, 16'h0005);
    sent = 0;
    while (sent < 1200) begin
      quiet = (sent > 500 && sent < 700);
      random_face();
      sent = vertices_sent;
    end
    vertex_valid <= 1'b0;
    last_vertex <= 1'b0;
    while (planes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
